>>> hdl/sed_pkg.sv
// shared types, character codes and helper functions for the string escape decoder
`default_nettype none

package sed_pkg;

    // one raw byte of the escaped string
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // one unescaped result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out_item;

    // all results caused by one input byte, count is 1 to 3
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            bare;
        logic            last;
    } t_bundle;

    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_X  = 8'h78;
    localparam logic [7:0] C_DIG_0  = 8'h30;
    localparam logic [7:0] C_DIG_7  = 8'h37;
    localparam logic [7:0] C_DIG_9  = 8'h39;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_F   = 8'h46;
    localparam logic [7:0] C_LOW_A  = 8'h61;
    localparam logic [7:0] C_LOW_B  = 8'h62;
    localparam logic [7:0] C_LOW_F  = 8'h66;
    localparam logic [7:0] C_LOW_N  = 8'h6E;
    localparam logic [7:0] C_LOW_R  = 8'h72;
    localparam logic [7:0] C_LOW_T  = 8'h74;
    localparam logic [7:0] C_LOW_V  = 8'h76;

    localparam logic [4:0] HEX_BAD = 5'd16;

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= C_DIG_0) && (c <= C_DIG_7);
    endfunction

    // 0..15 for a hex digit, HEX_BAD otherwise
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_BAD;
        if (c >= C_DIG_0 && c <= C_DIG_9) begin
            v = 5'(c - C_DIG_0);
        end else if (c >= C_UP_A && c <= C_UP_F) begin
            v = 5'(c - C_UP_A + 8'd10);
        end else if (c >= C_LOW_A && c <= C_LOW_F) begin
            v = 5'(c - C_LOW_A + 8'd10);
        end
        return v;
    endfunction

    // single-character escapes, anything else passes without its backslash
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            C_LOW_B: begin
                v = 8'h08;
            end
            C_LOW_F: begin
                v = 8'h0C;
            end
            C_LOW_N: begin
                v = 8'h0A;
            end
            C_LOW_R: begin
                v = 8'h0D;
            end
            C_LOW_T: begin
                v = 8'h09;
            end
            C_LOW_V: begin
                v = 8'h0B;
            end
            default: begin
                v = c;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sed_front.sv
// front end: takes raw bytes, tracks escape state and builds result bundles
`default_nettype none

module sed_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire sed_pkg::t_in_item i_item,
    output sed_pkg::t_bundle       o_bundle,
    output logic                   o_has_res
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_OCT    = 3'd2,
        M_HEX1   = 3'd3,
        M_HEX2   = 3'd4
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_first, n_first;

    logic [7:0]      c;
    logic [4:0]      hi, lo;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            bare;

    assign c  = i_item.in_byte;
    assign hi = sed_pkg::hex_val(r_first);
    assign lo = sed_pkg::hex_val(c);

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_first = r_first;
        cnt     = 2'd0;
        bytes   = '0;
        bare    = 1'b0;
        case (r_mode)
            M_ESC: begin
                n_mode = M_NORMAL;
                if (sed_pkg::is_octal(c)) begin
                    n_acc  = {5'd0, c[2:0]};
                    n_mode = M_OCT;
                end else if (c == sed_pkg::C_LOW_X) begin
                    n_mode = M_HEX1;
                end else begin
                    bytes[0] = sed_pkg::esc_map(c);
                    cnt      = 2'd1;
                end
            end
            M_OCT: begin
                if (sed_pkg::is_octal(c)) begin
                    n_acc = {r_acc[4:0], c[2:0]};
                end else begin
                    bytes[0] = r_acc;
                    cnt      = 2'd1;
                    n_mode   = M_NORMAL;
                    n_acc    = 8'd0;
                    if (c == sed_pkg::C_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        bytes[1] = c;
                        cnt      = 2'd2;
                    end
                end
            end
            M_HEX1: begin
                n_first = c;
                n_mode  = M_HEX2;
            end
            M_HEX2: begin
                if (hi != sed_pkg::HEX_BAD && lo != sed_pkg::HEX_BAD) begin
                    bytes[0] = {hi[3:0], lo[3:0]};
                    cnt      = 2'd1;
                end else begin
                    // bad hex: x and both bytes go out untouched
                    bytes[0] = sed_pkg::C_LOW_X;
                    bytes[1] = r_first;
                    bytes[2] = c;
                    cnt      = 2'd3;
                end
                n_mode  = M_NORMAL;
                n_first = 8'd0;
            end
            default: begin
                n_mode = M_NORMAL;
                if (c == sed_pkg::C_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    bytes[0] = c;
                    cnt      = 2'd1;
                end
            end
        endcase

        if (i_item.in_last) begin
            // close any open sequence at end of string
            case (n_mode)
                M_OCT: begin
                    bytes[cnt] = n_acc;
                    cnt        = 2'(cnt + 2'd1);
                end
                M_HEX1: begin
                    bytes[cnt] = sed_pkg::C_LOW_X;
                    cnt        = 2'(cnt + 2'd1);
                end
                M_HEX2: begin
                    bytes[0] = sed_pkg::C_LOW_X;
                    bytes[1] = n_first;
                    cnt      = 2'd2;
                end
                default: begin
                end
            endcase
            if (cnt == 2'd0) begin
                bare = 1'b1;
                cnt  = 2'd1;
            end
            n_mode  = M_NORMAL;
            n_acc   = 8'd0;
            n_first = 8'd0;
        end
    end

    assign o_bundle.cnt   = cnt;
    assign o_bundle.bytes = bytes;
    assign o_bundle.bare  = bare;
    assign o_bundle.last  = i_item.in_last;
    assign o_has_res      = cnt != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_acc   <= 8'd0;
            r_first <= 8'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sed_queue.sv
// bundle queue between front and back end
`default_nettype none

module sed_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire sed_pkg::t_bundle i_data,
    output logic                  o_full,
    input  wire logic             i_rd,
    output sed_pkg::t_bundle      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sed_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wptr + 1'b1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rptr + 1'b1);
            end
            if (wr_en && !rd_en) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (rd_en && !wr_en) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("front wrote a bundle while the queue was full");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

>>> hdl/sed_back.sv
// back end: hands out the results of the head bundle one per transfer
`default_nettype none

module sed_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sed_pkg::t_bundle i_head,
    input  wire logic             i_q_empty,
    output logic                  o_q_rd,
    input  wire logic             i_pop,
    output sed_pkg::t_out_item    o_item
);

    logic [1:0] r_idx;
    logic       at_end;

    assign at_end = r_idx == 2'(i_head.cnt - 2'd1);
    assign o_q_rd = i_pop && !i_q_empty && at_end;

    assign o_item.out_byte  = i_head.bare ? 8'd0 : i_head.bytes[r_idx];
    assign o_item.out_valid = !i_head.bare;
    assign o_item.out_last  = i_head.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (i_pop && !i_q_empty) begin
            r_idx <= at_end ? 2'd0 : 2'(r_idx + 2'd1);
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx < i_head.cnt))
        else $error("result index past end of bundle");

    a_bare_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && i_head.bare) |-> (i_head.cnt == 2'd1 && i_head.last))
        else $error("bare end marker shares a bundle");

endmodule

`default_nettype wire

>>> hdl/string_escape_decoder.sv
// top level of the string escape decoder
//
// usage: raw bytes of a string literal enter through the input queue port
// (push / full, payload i_item with in_byte and in_last). a byte transfers on
// a rising edge with push high and full low. unescaped bytes leave through
// the result queue port (empty / pop, payload o_item with out_byte,
// out_valid and out_last); the head result transfers when pop is high and
// empty is low.
// a result reaches o_item only once its bundle is registered in the queue.
// throughput: one byte per cycle in while full is low; one result per cycle
// out while pop is high and empty is low. an invalid hex escape produces
// three results from one byte, handed out while the front keeps taking bytes.
// a QUEUE_DEPTH entry bundle queue between front and back absorbs this and
// any stall on the result side; full rises only when that queue is full.
// reset: synchronous, active low; the decoder returns to plain text mode and
// the queue empties. a string whose last byte yields nothing still gets a
// bare end marker (out_valid low, out_last high).
`default_nettype none

module string_escape_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire sed_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output sed_pkg::t_out_item      o_item
);

    sed_pkg::t_bundle front_bundle;
    sed_pkg::t_bundle head_bundle;
    logic             front_has_res;
    logic             in_xfer;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;

    // a byte is taken only when the queue can hold whatever it produces
    assign full    = q_full;
    assign in_xfer = push && !q_full;
    // bytes that only move the escape state produce no bundle
    assign q_wr    = in_xfer && front_has_res;
    assign empty   = q_empty;

    sed_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_xfer),
        .i_item    (i_item),
        .o_bundle  (front_bundle),
        .o_has_res (front_has_res)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (front_bundle),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_data  (head_bundle),
        .o_empty (q_empty)
    );

    // back end walks the head bundle, releasing it after its final result
    sed_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head_bundle),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire
